// ===== rtl/circular_log_newer_count_assert.svh =====
// Assertion macros for the circular log block.
// Each macro checks on the rising clock edge and is muted while reset is high.
`ifndef CIRCULAR_LOG_NEWER_COUNT_ASSERT_SVH
`define CIRCULAR_LOG_NEWER_COUNT_ASSERT_SVH

// Same-cycle implication.
`define CLNC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("clnc check failed");

// Next-cycle implication.
`define CLNC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("clnc check failed");

`endif

// ===== rtl/clnc_pkg.sv =====
`timescale 1ns / 1ps

package clnc_pkg;

  localparam int CAPACITY = 512;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 10;
  localparam int STAMP_W  = 32;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_COUNT  = 1'b1;

  // Item classes decided at the front.
  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_ALL    = 2'd1;
  localparam logic [1:0] KIND_SEARCH = 2'd2;

  typedef struct packed {
    logic               cmd;
    logic [STAMP_W-1:0] stamp;
  } in_t;

  typedef struct packed {
    logic [CNT_W-1:0] newer_count;
    logic [CNT_W-1:0] stored_total;
  } out_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [STAMP_W-1:0] stamp;
  } q_entry_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [STAMP_W-1:0] wdata;
    logic [ADDR_W-1:0]  raddr;
  } mem_req_t;

endpackage

// ===== rtl/circular_log_newer_count.sv =====
`timescale 1ns / 1ps
// Sequence, queue empty: an append is written and answered when the back pops it;
// a count runs two end checks, then an issue state and a compare state per search
// probe, at most ceil(log2(CAPACITY+1)) probes, all through the one read port of the store.
// Throughput: one append per cycle sustained while no count is searching; a 2-entry
// queue takes items while a count searches. Results are strobed on done for one cycle.
// Reset (rst, synchronous): empties the queue and the store count at once.
module circular_log_newer_count (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  clnc_pkg::in_t  item,
  output logic           done,
  output clnc_pkg::out_t result
);
  import clnc_pkg::*;

  // Front to back: queue head and pop.
  logic     q_valid;
  q_entry_t q_head;
  logic     q_pop;

  // Back to store.
  mem_req_t           mem;
  logic [STAMP_W-1:0] mem_rdata;

  // Front: take each beat while the queue has room, tag it with its class
  // (append, count-all, count-with-search) and hold it until the back pops.
  clnc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .item    (item),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  // Back: carry out one item at a time. Appends write the store and advance
  // the fill count or the wrap position; counts other than count-all run the end
  // checks and then the binary search over the logical order, oldest first.
  clnc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .mem       (mem),
    .mem_rdata (mem_rdata),
    .done      (done),
    .result    (result)
  );

  // Timestamp store: one write port, one registered read port. Only entries
  // below the fill count are ever used, so it needs no clearing.
  clnc_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .raddr (mem.raddr),
    .rdata (mem_rdata)
  );

endmodule

// ===== rtl/clnc_ram.sv =====
`timescale 1ns / 1ps

module clnc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/clnc_front.sv =====
`timescale 1ns / 1ps

module clnc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  clnc_pkg::in_t    item,
  output logic             q_valid,
  output clnc_pkg::q_entry_t q_head,
  input  logic             q_pop
);
  import clnc_pkg::*;

  q_entry_t   slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       push;
  q_entry_t   entry;

  assign busy    = (count == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_head  = slot[rd_ptr];

  // Classify: a count from time zero needs no search.
  always_comb begin
    entry.stamp = item.stamp;
    if (item.cmd == CMD_APPEND) begin
      entry.kind = KIND_APPEND;
    end else if (item.stamp == '0) begin
      entry.kind = KIND_ALL;
    end else begin
      entry.kind = KIND_SEARCH;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/clnc_back.sv =====
`timescale 1ns / 1ps

module clnc_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  clnc_pkg::q_entry_t           q_head,
  output logic                         q_pop,
  output clnc_pkg::mem_req_t           mem,
  input  logic [clnc_pkg::STAMP_W-1:0] mem_rdata,
  output logic                         done,
  output clnc_pkg::out_t               result
);
  import clnc_pkg::*;

  localparam int SW = CNT_W + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OLD   = 3'd1;
  localparam logic [2:0] S_NEW   = 3'd2;
  localparam logic [2:0] S_ISSUE = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;

  function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] base,
                                             input logic [ADDR_W-1:0] off);
    logic [ADDR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (ADDR_W+1)'(CAPACITY)) begin
      sum = sum - (ADDR_W+1)'(CAPACITY);
    end
    return sum[ADDR_W-1:0];
  endfunction

  logic [2:0]           state;
  logic [CNT_W-1:0]     fill;
  logic [ADDR_W-1:0]    wrap;
  logic [STAMP_W-1:0]   since;
  logic signed [SW-1:0] low;
  logic signed [SW-1:0] high;
  logic [ADDR_W-1:0]    mid_q;
  logic [ADDR_W-1:0]    first;
  logic                 found;

  logic                 full;
  logic [ADDR_W-1:0]    oldest;
  logic [CNT_W-1:0]     fill_m1;
  logic [ADDR_W-1:0]    newest;
  logic signed [SW-1:0] diff;
  logic signed [SW-1:0] mid_full;
  logic [ADDR_W-1:0]    mid;
  logic signed [SW-1:0] mid_ext;
  logic                 hit;
  logic signed [SW-1:0] low_next;
  logic signed [SW-1:0] high_next;
  logic [ADDR_W-1:0]    first_next;
  logic                 found_next;
  logic [CNT_W-1:0]     search_count;

  assign full     = (fill == CNT_W'(CAPACITY));
  assign oldest   = full ? wrap : '0;
  assign fill_m1  = fill - CNT_W'(1);
  assign newest   = phys(oldest, fill_m1[ADDR_W-1:0]);
  assign diff     = high - low;
  assign mid_full = low + (diff >>> 1);
  assign mid      = mid_full[ADDR_W-1:0];
  assign mid_ext  = SW'({{(SW-ADDR_W){1'b0}}, mid_q});

  // Narrow the window on the probe just read.
  assign hit        = (mem_rdata > since);
  assign low_next   = hit ? low : (mid_ext + SW'(1));
  assign high_next  = hit ? (mid_ext - SW'(1)) : high;
  assign first_next = hit ? mid_q : first;
  assign found_next = found || hit;
  assign search_count = found_next ?
                        (fill - {{(CNT_W-ADDR_W){1'b0}}, first_next}) : '0;

  assign q_pop = (state == S_IDLE) && q_valid;

  // Issue each probe at the fresh midpoint; its data meets mid_q in S_CMP.
  always_comb begin
    mem.we    = q_pop && (q_head.kind == KIND_APPEND);
    mem.waddr = full ? wrap : fill[ADDR_W-1:0];
    mem.wdata = q_head.stamp;
    unique case (state)
      S_IDLE:  mem.raddr = oldest;
      S_OLD:   mem.raddr = newest;
      S_ISSUE: mem.raddr = phys(oldest, mid);
      default: mem.raddr = phys(oldest, mid_q);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      wrap  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            since <= q_head.stamp;
            unique case (q_head.kind)
              KIND_APPEND: begin
                done <= 1'b1;
                result.newer_count <= '0;
                if (!full) begin
                  fill <= fill + CNT_W'(1);
                  wrap <= '0;
                  result.stored_total <= fill + CNT_W'(1);
                end else begin
                  wrap <= (wrap == ADDR_W'(CAPACITY - 1)) ? '0 : wrap + ADDR_W'(1);
                  result.stored_total <= fill;
                end
              end
              KIND_ALL: begin
                done <= 1'b1;
                result.newer_count  <= fill;
                result.stored_total <= fill;
              end
              default: begin
                if (fill == '0) begin
                  done <= 1'b1;
                  result.newer_count  <= '0;
                  result.stored_total <= fill;
                end else begin
                  state <= S_OLD;
                end
              end
            endcase
          end
        end
        S_OLD: begin
          if (since < mem_rdata) begin
            done <= 1'b1;
            result.newer_count  <= fill;
            result.stored_total <= fill;
            state <= S_IDLE;
          end else begin
            state <= S_NEW;
          end
        end
        S_NEW: begin
          if (since >= mem_rdata) begin
            done <= 1'b1;
            result.newer_count  <= '0;
            result.stored_total <= fill;
            state <= S_IDLE;
          end else begin
            low   <= '0;
            high  <= SW'({1'b0, fill_m1});
            found <= 1'b0;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          mid_q <= mid;
          state <= S_CMP;
        end
        S_CMP: begin
          low   <= low_next;
          high  <= high_next;
          first <= first_next;
          found <= found_next;
          if (low_next <= high_next) begin
            state <= S_ISSUE;
          end else begin
            done <= 1'b1;
            result.newer_count  <= search_count;
            result.stored_total <= fill;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/clnc_checker.sv =====
`timescale 1ns / 1ps
`include "circular_log_newer_count_assert.svh"

module clnc_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input clnc_pkg::in_t  item,
  input logic           done,
  input clnc_pkg::out_t result
);
  import clnc_pkg::*;

  // Track beats accepted but not yet answered.
  logic [2:0] pending;
  logic       accept;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {2'b0, accept} - {2'b0, done};
    end
  end

  `CLNC_ASSERT_NOW(a_count_le_total, done, result.newer_count <= result.stored_total)
  `CLNC_ASSERT_NOW(a_total_le_cap, done, result.stored_total <= CNT_W'(CAPACITY))
  `CLNC_ASSERT_NOW(a_no_spurious_result, done, pending != 3'd0)
  `CLNC_ASSERT_NOW(a_in_flight_bounded, 1'b1, pending <= 3'd4)
  `CLNC_ASSERT_NEXT(a_append_total, accept && item.cmd == CMD_APPEND && pending == 3'd0,
                    !done)

endmodule

bind circular_log_newer_count clnc_checker u_checker (.*);
